FILE: hw/rtl/ksc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksc_pkg
// shared types, codes and constants of the keyboard serial controller
// ----------------------------------------------------------------------------
package ksc_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int CMD_DEPTH_DEF   = 4;
  localparam int KEY_COUNT       = 128;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_KEY  = 2'd1;
  localparam logic [1:0] FUNC_HS   = 2'd2;

  localparam logic [2:0] CFG_BIT_HALF    = 3'd0;
  localparam logic [2:0] CFG_ACK_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_ACK_MIN     = 3'd2;
  localparam logic [2:0] CFG_RESET_HOLD  = 3'd3;
  localparam logic [2:0] CFG_SELFTEST    = 3'd4;

  localparam logic [7:0] CODE_RESYNC_END = 8'hf9;
  localparam logic [7:0] CODE_OVERFLOW   = 8'hfa;
  localparam logic [7:0] CODE_INIT_START = 8'hfd;
  localparam logic [7:0] CODE_INIT_END   = 8'hfe;
  localparam logic [6:0] KEY_CAPS        = 7'h62;
  localparam logic [6:0] KEY_CTRL        = 7'h63;
  localparam logic [6:0] KEY_LAMIGA      = 7'h66;
  localparam logic [6:0] KEY_RAMIGA      = 7'h67;
  localparam logic [7:0] RELEASE_BIT     = 8'h80;
  localparam logic [23:0] MAX24          = 24'hffffff;

  typedef enum logic [6:0] {
    EV_NONE      = 7'b0000001,
    EV_SELFTEST  = 7'b0000010,
    EV_XFER      = 7'b0000100,
    EV_XFER_LOW  = 7'b0001000,
    EV_XFER_HIGH = 7'b0010000,
    EV_WAIT      = 7'b0100000,
    EV_HARDRESET = 7'b1000000
  } event_t;

  typedef enum logic [5:0] {
    MODE_SELFTEST  = 6'b000001,
    MODE_INITIATE  = 6'b000010,
    MODE_TERMINATE = 6'b000100,
    MODE_SEND      = 6'b001000,
    MODE_LOST_INIT = 6'b010000,
    MODE_LOST_XMIT = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] key_code;
    logic       key_pressed;
    logic       handshake_level;
  } cmd_t;

  typedef struct packed {
    logic clock_line;
    logic data_bit;
    logic reset_out;
    logic caps_led;
  } levels_t;

endpackage

FILE: hw/rtl/ksc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksc_front
// input side: takes words, packs them into commands and buffers them in the command queue
// ----------------------------------------------------------------------------
module ksc_front #(
  parameter int DEPTH = ksc_pkg::CMD_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_func,
  input  logic [6:0]    in_key_code,
  input  logic          in_key_pressed,
  input  logic          in_handshake_level,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output ksc_pkg::cmd_t cmd
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  ksc_pkg::cmd_t    mem_r [DEPTH];
  logic [AW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]      cnt_r, cnt_nxt;
  ksc_pkg::cmd_t    in_cmd;
  logic             push, pop;

  always_comb begin
    in_cmd.func            = in_func;
    in_cmd.key_code        = in_key_code;
    in_cmd.key_pressed     = in_key_pressed;
    in_cmd.handshake_level = in_handshake_level;
  end

  assign in_ready  = (cnt_r != (AW+1)'(DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem_r[rd_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == AW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
    end
    if (pop) begin
      rd_nxt = (rd_r == AW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/ksc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksc_core
// protocol engine: delay slot, bit cells, handshake, stroke queue, key map
// ----------------------------------------------------------------------------
module ksc_core #(
  parameter int QUEUE_DEPTH = ksc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [23:0]     cfg_data,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  ksc_pkg::cmd_t   cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output ksc_pkg::levels_t res
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W = ksc_pkg::KEY_COUNT;

  logic [15:0] bit_half_r, ack_min_r;
  logic [23:0] ack_timeout_r, reset_hold_r, selftest_r;

  ksc_pkg::mode_t  mode_r, mode_nxt, saved_r, saved_nxt;
  ksc_pkg::event_t ev_r, ev_nxt;
  logic [23:0] cd_r, cd_nxt, hs_r, hs_nxt;
  logic [7:0]  sh_r, sh_nxt, last_r, last_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic        ovf_r, ovf_nxt, caps_r, caps_nxt, hrf_r, hrf_nxt;
  logic [KEY_W-1:0] keys_r, keys_nxt;
  logic [7:0]  q_r [QUEUE_DEPTH];
  logic [CW-1:0] qc_r, qc_nxt;
  logic [QW-1:0] qh_r, qh_nxt, qt_r, qt_nxt;
  logic        clk_r, clk_nxt, dat_r, dat_nxt, rst_r, rst_nxt, led_r, led_nxt;
  logic        q_we;
  logic [QW-1:0] q_wa;
  logic [7:0]  q_wd;
  logic        step;

  assign cmd_ready = !res_valid || res_ready;
  assign step      = cmd_valid && cmd_ready;

  function automatic logic [23:0] nz(input logic [23:0] t);
    nz = (t == '0) ? 24'd1 : t;
  endfunction

  function automatic logic [7:0] enc(input logic [7:0] c);
    enc = ~{c[6:0], c[7]};
  endfunction

  always_comb begin
    logic       fire, three, do_send, pop, ret;
    logic [7:0] code, stroke, qv;
    logic [6:0] k;
    mode_nxt = mode_r;  saved_nxt = saved_r;  ev_nxt = ev_r;  cd_nxt = cd_r;
    hs_nxt = hs_r;      sh_nxt = sh_r;        last_nxt = last_r;
    bits_nxt = bits_r;  ovf_nxt = ovf_r;      caps_nxt = caps_r;
    hrf_nxt = hrf_r;    keys_nxt = keys_r;    qc_nxt = qc_r;
    qh_nxt = qh_r;      qt_nxt = qt_r;        clk_nxt = clk_r;
    dat_nxt = dat_r;    rst_nxt = rst_r;      led_nxt = led_r;
    q_we = 1'b0;        q_wd = '0;            q_wa = '0;
    fire = 1'b0;        do_send = 1'b0;       pop = 1'b0;  ret = 1'b0;
    code = '0;          k = cmd.key_code;     stroke = {1'b0, k};
    qv = q_r[qh_r];
    three = 1'b0;
    unique case (cmd.func)
      ksc_pkg::FUNC_TICK: begin
        if (hs_r != ksc_pkg::MAX24) begin
          hs_nxt = hs_r + 1'b1;
        end
        if (ev_r != ksc_pkg::EV_NONE) begin
          if (cd_r <= 24'd1) begin
            cd_nxt = '0;
            ev_nxt = ksc_pkg::EV_NONE;
            fire = 1'b1;
          end else begin
            cd_nxt = cd_r - 1'b1;
          end
        end
        if (fire) begin
          unique case (ev_r)
            ksc_pkg::EV_SELFTEST: begin
              bits_nxt = 4'd1; sh_nxt = '0;
              ev_nxt = ksc_pkg::EV_XFER; cd_nxt = nz({8'd0, bit_half_r});
            end
            ksc_pkg::EV_XFER: begin
              if (bits_r == '0) begin
                ev_nxt = ksc_pkg::EV_WAIT; cd_nxt = nz(ack_timeout_r);
              end else begin
                ev_nxt = ksc_pkg::EV_XFER_LOW; cd_nxt = nz({8'd0, bit_half_r});
              end
            end
            ksc_pkg::EV_XFER_LOW: begin
              clk_nxt = 1'b0;
              ev_nxt = ksc_pkg::EV_XFER_HIGH; cd_nxt = nz({8'd0, bit_half_r});
            end
            ksc_pkg::EV_XFER_HIGH: begin
              clk_nxt = 1'b1;
              dat_nxt = sh_r[7];
              sh_nxt = {sh_r[6:0], 1'b0};
              if (bits_r != '0) begin
                bits_nxt = bits_r - 1'b1;
              end
              ev_nxt = ksc_pkg::EV_XFER; cd_nxt = nz({8'd0, bit_half_r});
            end
            ksc_pkg::EV_WAIT: begin
              if (mode_r != ksc_pkg::MODE_SELFTEST) begin
                if (mode_r != ksc_pkg::MODE_LOST_INIT &&
                    mode_r != ksc_pkg::MODE_LOST_XMIT) begin
                  saved_nxt = mode_r;
                end
                mode_nxt = ksc_pkg::MODE_LOST_INIT;
              end
              bits_nxt = 4'd1; sh_nxt = '0;
              ev_nxt = ksc_pkg::EV_XFER; cd_nxt = nz({8'd0, bit_half_r});
            end
            ksc_pkg::EV_HARDRESET: begin
              if (!(keys_r[ksc_pkg::KEY_CTRL] && keys_r[ksc_pkg::KEY_LAMIGA] &&
                    keys_r[ksc_pkg::KEY_RAMIGA])) begin
                rst_nxt = 1'b0;
                mode_nxt = ksc_pkg::MODE_SELFTEST; ovf_nxt = 1'b0;
                caps_nxt = 1'b0; hrf_nxt = 1'b0; bits_nxt = 4'd1;
                sh_nxt = '0; keys_nxt = '0; led_nxt = 1'b1;
                qc_nxt = '0; qh_nxt = '0; qt_nxt = '0;
                ev_nxt = ksc_pkg::EV_SELFTEST; cd_nxt = nz(selftest_r);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ksc_pkg::FUNC_HS: begin
        if (!hrf_r) begin
          if (!cmd.handshake_level) begin
            hs_nxt = '0;
          end else if (hs_r > {8'd0, ack_min_r} && ev_r == ksc_pkg::EV_WAIT) begin
            do_send = 1'b1;
            priority if (ovf_r) begin
              ovf_nxt = 1'b0; code = ksc_pkg::CODE_OVERFLOW;
            end else if (mode_r == ksc_pkg::MODE_LOST_INIT) begin
              mode_nxt = ksc_pkg::MODE_LOST_XMIT; code = ksc_pkg::CODE_RESYNC_END;
            end else if (mode_r == ksc_pkg::MODE_LOST_XMIT) begin
              mode_nxt = saved_r; code = last_r;
            end else if (mode_r == ksc_pkg::MODE_SELFTEST) begin
              mode_nxt = ksc_pkg::MODE_INITIATE; code = ksc_pkg::CODE_INIT_START;
            end else if (mode_r == ksc_pkg::MODE_INITIATE) begin
              if (qc_r != '0) begin
                pop = 1'b1; code = qv;
              end else begin
                mode_nxt = ksc_pkg::MODE_TERMINATE; code = ksc_pkg::CODE_INIT_END;
              end
            end else begin
              if (mode_r == ksc_pkg::MODE_TERMINATE) begin
                led_nxt = 1'b0; mode_nxt = ksc_pkg::MODE_SEND;
              end
              if (qc_r != '0) begin
                pop = 1'b1; code = qv;
              end else begin
                do_send = 1'b0; ev_nxt = ksc_pkg::EV_NONE;
              end
            end
          end
        end
      end
      ksc_pkg::FUNC_KEY: begin
        if (cmd.key_pressed) begin
          if (keys_r[k]) begin
            ret = 1'b1;
          end else begin
            keys_nxt[k] = 1'b1;
          end
        end else begin
          if (!keys_r[k] || k == ksc_pkg::KEY_CAPS) begin
            ret = 1'b1;
          end
          keys_nxt[k] = 1'b0;
          stroke = stroke | ksc_pkg::RELEASE_BIT;
        end
        if (!ret) begin
          three = keys_nxt[ksc_pkg::KEY_CTRL] && keys_nxt[ksc_pkg::KEY_LAMIGA] &&
                  keys_nxt[ksc_pkg::KEY_RAMIGA];
          if (three) begin
            if (!hrf_r) begin
              hrf_nxt = 1'b1; rst_nxt = 1'b1;
              ev_nxt = ksc_pkg::EV_HARDRESET; cd_nxt = nz(reset_hold_r);
            end
          end else if (hrf_r && ev_r != ksc_pkg::EV_HARDRESET) begin
            rst_nxt = 1'b0;
            mode_nxt = ksc_pkg::MODE_SELFTEST; ovf_nxt = 1'b0;
            caps_nxt = 1'b0; hrf_nxt = 1'b0; bits_nxt = 4'd1;
            sh_nxt = '0; keys_nxt = '0; led_nxt = 1'b1;
            qc_nxt = '0; qh_nxt = '0; qt_nxt = '0;
            ev_nxt = ksc_pkg::EV_SELFTEST; cd_nxt = nz(selftest_r);
          end
          if (!hrf_nxt && !(three && hrf_r)) begin
            if (qc_nxt == CW'(QUEUE_DEPTH)) begin
              ovf_nxt = 1'b1;
            end else if (stroke[6:0] == ksc_pkg::KEY_CAPS && !stroke[7] &&
                         mode_nxt != ksc_pkg::MODE_SEND) begin
            end else begin
              if (stroke[6:0] == ksc_pkg::KEY_CAPS && !stroke[7]) begin
                caps_nxt = ~caps_r;
                led_nxt = ~caps_r;
                if (caps_r) begin
                  stroke = stroke | ksc_pkg::RELEASE_BIT;
                end
              end
              if (ev_nxt != ksc_pkg::EV_NONE) begin
                q_we = 1'b1; q_wd = stroke; q_wa = qt_nxt;
                qt_nxt = (qt_nxt == QW'(QUEUE_DEPTH-1)) ? '0 : qt_nxt + 1'b1;
                qc_nxt = qc_nxt + 1'b1;
              end else begin
                do_send = 1'b1; code = stroke;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (pop) begin
      qh_nxt = (qh_r == QW'(QUEUE_DEPTH-1)) ? '0 : qh_r + 1'b1;
      qc_nxt = qc_r - 1'b1;
    end
    if (do_send) begin
      if (code != ksc_pkg::CODE_RESYNC_END) begin
        last_nxt = code;
      end
      bits_nxt = 4'd8;
      sh_nxt = enc(code);
      ev_nxt = ksc_pkg::EV_XFER;
      cd_nxt = nz({8'd0, bit_half_r});
    end
  end

  always_ff @(posedge clk) begin
    if (step && q_we) begin
      q_r[q_wa] <= q_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_half_r    <= 16'd71;
      ack_timeout_r <= 24'd507000;
      ack_min_r     <= 16'd4;
      reset_hold_r  <= 24'd1773000;
      selftest_r    <= 24'd3546000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ksc_pkg::CFG_BIT_HALF:    bit_half_r    <= cfg_data[15:0];
        ksc_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
        ksc_pkg::CFG_ACK_MIN:     ack_min_r     <= cfg_data[15:0];
        ksc_pkg::CFG_RESET_HOLD:  reset_hold_r  <= cfg_data;
        ksc_pkg::CFG_SELFTEST:    selftest_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ksc_pkg::MODE_SELFTEST; saved_r <= ksc_pkg::MODE_SELFTEST;
      ev_r <= ksc_pkg::EV_SELFTEST;     cd_r <= 24'd3546000;
      hs_r <= '0;  sh_r <= '0;  last_r <= '0;  bits_r <= 4'd1;
      ovf_r <= 1'b0; caps_r <= 1'b0; hrf_r <= 1'b0; keys_r <= '0;
      qc_r <= '0; qh_r <= '0; qt_r <= '0;
      clk_r <= 1'b1; dat_r <= 1'b0; rst_r <= 1'b0; led_r <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        mode_r <= mode_nxt; saved_r <= saved_nxt; ev_r <= ev_nxt; cd_r <= cd_nxt;
        hs_r <= hs_nxt; sh_r <= sh_nxt; last_r <= last_nxt; bits_r <= bits_nxt;
        ovf_r <= ovf_nxt; caps_r <= caps_nxt; hrf_r <= hrf_nxt; keys_r <= keys_nxt;
        qc_r <= qc_nxt; qh_r <= qh_nxt; qt_r <= qt_nxt;
        clk_r <= clk_nxt; dat_r <= dat_nxt; rst_r <= rst_nxt; led_r <= led_nxt;
      end
      if (step) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.clock_line <= clk_nxt;
      res.data_bit   <= dat_nxt;
      res.reset_out  <= rst_nxt;
      res.caps_led   <= led_nxt;
    end
  end

endmodule

FILE: hw/rtl/keyboard_serial_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_serial_controller
// keyboard side of a clocked serial key link
// ----------------------------------------------------------------------------
// a word's levels are presented once the word has passed the command queue
// and then the registered protocol engine step
// throughput: one word per cycle while out_ready keeps the output flowing
// reset: synchronous active low; registers return to defaults, the selftest
// delay is armed and the key map and stroke queue are emptied at once
module keyboard_serial_controller #(
  parameter int QUEUE_DEPTH = ksc_pkg::QUEUE_DEPTH_DEF,
  parameter int CMD_DEPTH   = ksc_pkg::CMD_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [6:0]  in_key_code,
  input  logic        in_key_pressed,
  input  logic        in_handshake_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_clock_line,
  output logic        out_data_bit,
  output logic        out_reset_out,
  output logic        out_caps_led
);

  ksc_pkg::cmd_t    cmd;
  ksc_pkg::levels_t res;
  logic             cmd_valid, cmd_ready;

  ksc_front #(.DEPTH(CMD_DEPTH)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_key_code,
    .in_key_pressed, .in_handshake_level, .cmd_valid, .cmd_ready, .cmd
  );

  ksc_core #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_core (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .cmd_valid, .cmd_ready, .cmd,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign out_clock_line = res.clock_line;
  assign out_data_bit   = res.data_bit;
  assign out_reset_out  = res.reset_out;
  assign out_caps_led   = res.caps_led;

endmodule
